### hdl/n2w_pkg.sv
// shared types, constants and codes for the number to word token block
package n2w_pkg;

  // input number width and decimal layout
  localparam int NUM_W          = 40;
  localparam int DIGITS         = 12;
  localparam int DIGIT_W        = 4;
  localparam int BCD_W          = DIGITS * DIGIT_W;
  localparam int BITS_PER_STAGE = 4;
  localparam int STAGES         = NUM_W / BITS_PER_STAGE;

  // groups of three digits that are named (1 to 4)
  localparam int GROUP_COUNT    = 4;
  localparam int SLOTS_PER_GRP  = 5;
  localparam int SLOTS          = GROUP_COUNT * SLOTS_PER_GRP;
  localparam int SLOT_IDX_W     = $clog2(SLOTS);

  localparam int CODE_W         = 5;

  typedef logic [CODE_W-1:0] word_code_t;
  typedef logic [SLOTS-1:0]  slot_mask_t;
  typedef word_code_t [SLOTS-1:0] slot_codes_t;

  // word codes
  localparam word_code_t CODE_NONE      = 5'd0;
  localparam word_code_t CODE_TEN       = 5'd10;
  localparam word_code_t CODE_TENS_BASE = 5'd18;
  localparam word_code_t CODE_HUNDRED   = 5'd28;

  // data carried through the conversion pipeline
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [NUM_W-1:0] bin;
  } bcd_stage_t;

endpackage

### hdl/n2w_bcd_stage.sv
// one pipeline stage of the shift-and-add-three binary to decimal conversion
module n2w_bcd_stage
  import n2w_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  bcd_stage_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output bcd_stage_t dn_data
);

  logic       valid_r;
  logic       valid_nxt;
  bcd_stage_t data_r;
  bcd_stage_t data_nxt;

  // four bits shifted in per stage, digits adjusted before each shift
  always_comb begin
    bcd_stage_t work;
    work = up_data;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (work.bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          work.bcd[d*DIGIT_W +: DIGIT_W] = work.bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      work.bcd = {work.bcd[BCD_W-2:0], work.bin[NUM_W-1]};
      work.bin = {work.bin[NUM_W-2:0], 1'b0};
    end
    data_nxt = work;
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### hdl/n2w_token_build.sv
// stage that turns decimal digits into a slot mask and word codes
module n2w_token_build
  import n2w_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  bcd_stage_t  up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output slot_mask_t  dn_mask,
  output slot_codes_t dn_codes
);

  logic        valid_r;
  slot_mask_t  mask_r;
  slot_mask_t  mask_nxt;
  slot_codes_t codes_r;
  slot_codes_t codes_nxt;

  always_comb begin
    logic [DIGIT_W-1:0] h;
    logic [DIGIT_W-1:0] t;
    logic [DIGIT_W-1:0] o;
    int                 b;
    mask_nxt  = '0;
    codes_nxt = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      h = up_data.bcd[(3*g+2)*DIGIT_W +: DIGIT_W];
      t = up_data.bcd[(3*g+1)*DIGIT_W +: DIGIT_W];
      o = up_data.bcd[(3*g)*DIGIT_W +: DIGIT_W];
      b = (GROUP_COUNT - 1 - g) * SLOTS_PER_GRP;
      // hundreds digit and hundred
      mask_nxt[b]      = (h != '0);
      codes_nxt[b]     = {1'b0, h};
      mask_nxt[b+1]    = (h != '0);
      codes_nxt[b+1]   = CODE_HUNDRED;
      // teen word or tens word
      mask_nxt[b+2]    = (t != '0);
      codes_nxt[b+2]   = (t == 4'd1) ? CODE_TEN + {1'b0, o} : CODE_TENS_BASE + {1'b0, t};
      // ones word, folded into the teen otherwise
      mask_nxt[b+3]    = (t != 4'd1) && (o != '0);
      codes_nxt[b+3]   = {1'b0, o};
      // scale word for non-empty groups above the lowest
      mask_nxt[b+4]    = (g != 0) && ((h != '0) || (t != '0) || (o != '0));
      codes_nxt[b+4]   = CODE_HUNDRED + CODE_W'(g);
    end
    // nothing to say: a single none token
    if (mask_nxt == '0) begin
      mask_nxt[0]  = 1'b1;
      codes_nxt[0] = CODE_NONE;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mask_r  <= mask_nxt;
      codes_r <= codes_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_mask  = mask_r;
  assign dn_codes = codes_r;

endmodule

### hdl/n2w_token_ser.sv
// token serialiser: one word token per cycle into the output register when free
module n2w_token_ser
  import n2w_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  slot_mask_t  up_mask,
  input  slot_codes_t up_codes,
  output logic        out_valid,
  input  logic        out_ready,
  output word_code_t  out_word_code,
  output logic        out_last_word
);

  slot_mask_t  mask_r;
  slot_mask_t  mask_nxt;
  slot_codes_t codes_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  word_code_t  out_code_r;
  logic        out_last_r;

  logic                  slot_free;
  logic                  has;
  logic                  emit;
  logic                  load;
  slot_mask_t            sel;
  slot_mask_t            rem;
  logic [SLOT_IDX_W-1:0] sel_idx;

  // lowest pending slot goes out first
  always_comb begin
    logic found;
    found   = 1'b0;
    sel     = '0;
    sel_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (mask_r[i] && !found) begin
        found   = 1'b1;
        sel[i]  = 1'b1;
        sel_idx = SLOT_IDX_W'(i);
      end
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign has       = |mask_r;
  assign emit      = slot_free && has;
  assign rem       = mask_r & ~sel;
  assign load      = !has || (emit && (rem == '0));
  assign up_ready  = load;

  always_comb begin
    if (load) begin
      mask_nxt = up_valid ? up_mask : '0;
    end else if (emit) begin
      mask_nxt = rem;
    end else begin
      mask_nxt = mask_r;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      codes_r <= up_codes;
    end
    if (emit) begin
      out_code_r <= codes_r[sel_idx];
      out_last_r <= (rem == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word_code = out_code_r;
  assign out_last_word = out_last_r;

endmodule

### hdl/number_to_word_tokens_top.sv
// top level: names a 40-bit number as a run of english word tokens; its digits from
// one trillion up are dropped
// throughput: one token per cycle while out_ready is high; a number gives
//   1 to 19 tokens, and the serialiser loads the next as its last token leaves
// reset: synchronous active-low rst_n empties every stage and the output
module number_to_word_tokens_top
  import n2w_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] in_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CODE_W-1:0] out_word_code,
  output logic             out_last_word
);

  // conversion pipeline: each stage shifts four bits into the decimal digits
  logic       stg_valid [STAGES+1];
  logic       stg_ready [STAGES+1];
  bcd_stage_t stg_data  [STAGES+1];

  // digits-to-slots stage towards the serialiser
  logic        bld_valid;
  logic        bld_ready;
  slot_mask_t  bld_mask;
  slot_codes_t bld_codes;

  // pipeline entry: empty digit register, number in the binary field
  assign stg_valid[0]    = in_valid;
  assign in_ready        = stg_ready[0];
  assign stg_data[0].bcd = '0;
  assign stg_data[0].bin = in_number;

  for (genvar s = 0; s < STAGES; s++) begin : g_bcd
    n2w_bcd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[s]),
      .up_ready (stg_ready[s]),
      .up_data  (stg_data[s]),
      .dn_valid (stg_valid[s+1]),
      .dn_ready (stg_ready[s+1]),
      .dn_data  (stg_data[s+1])
    );
  end

  // each group of three digits becomes up to five word slots
  n2w_token_build u_build (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stg_valid[STAGES]),
    .up_ready (stg_ready[STAGES]),
    .up_data  (stg_data[STAGES]),
    .dn_valid (bld_valid),
    .dn_ready (bld_ready),
    .dn_mask  (bld_mask),
    .dn_codes (bld_codes)
  );

  // slots leave one per cycle unless stalled; the next number loads as last goes
  n2w_token_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (bld_valid),
    .up_ready      (bld_ready),
    .up_mask       (bld_mask),
    .up_codes      (bld_codes),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word_code (out_word_code),
    .out_last_word (out_last_word)
  );

endmodule

### hdl/n2w_checker.sv
// port-level checker for the number to word token block, bound to the top level
module n2w_checker
  import n2w_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [NUM_W-1:0]  in_number,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] out_word_code,
  input logic              out_last_word
);

  // an offered number waits unchanged until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_number))
    else $error("input changed while stalled");

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_code) && $stable(out_last_word))
    else $error("result changed while stalled");

  // the none token is always the last of its run
  a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word_code == CODE_NONE) |-> out_last_word)
    else $error("none token not last of its run");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // input side must be able to take a number after reset has settled
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind number_to_word_tokens_top n2w_checker u_n2w_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_number     (in_number),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_word_code (out_word_code),
  .out_last_word (out_last_word)
);

### verif/tb_top.sv
// self-checking testbench for the number to word token block
module tb_top;
  import n2w_pkg::*;

  // one expected token of a number's run
  typedef struct packed {
    word_code_t word_code;
    logic       last_word;
  } word_token_t;

  // ready patterns the receiver cycles through
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_MOSTLY
  } rx_pattern_t;

  localparam int unsigned     WATCHDOG_LIMIT = 2000;
  localparam int unsigned     LONG_HOLD      = 300;
  // tail after the drain, leaving room for stray tokens to show up
  localparam int unsigned     TAIL_CYCLES    = 40;
  localparam longint unsigned TRILLION       = 64'd1000000000000;
  // numbers from one trillion up to the top of the 40-bit field
  localparam longint unsigned ABOVE_SPAN     = (64'd1 << NUM_W) - TRILLION;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [NUM_W-1:0] in_number     = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic [CODE_W-1:0] out_word_code;
  logic             out_last_word;

  word_token_t expected_tokens[$];
  int unsigned error_count    = 0;
  int unsigned tokens_checked = 0;
  int unsigned idle_cycles    = 0;

  // sender burst control, owned by the stimulus process
  bit          sender_gaps_on = 1'b1;
  int unsigned burst_left     = 0;

  // long receiver hold-off: the stimulus raises requests, the receiver serves them
  int unsigned stall_requests = 0;
  int unsigned stalls_served  = 0;

  // receiver pattern state, owned by the receiver process
  rx_pattern_t rx_mode      = RX_ALWAYS;
  int unsigned stretch_left = 0;
  int unsigned hold_left    = 0;
  int unsigned rx_period    = 2;
  int unsigned rx_phase     = 0;

  number_to_word_tokens_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word_code (out_word_code),
    .out_last_word (out_last_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction: the english word tokens of a number, groups of three digits,
  // most significant group first
  // ---------------------------------------------------------------------------
  function automatic void predict_tokens(input logic [NUM_W-1:0] number);
    longint unsigned remaining;
    int unsigned     groups[GROUP_COUNT];
    int unsigned     hundreds;
    int unsigned     rest;
    int unsigned     group_start;
    word_code_t      codes[$];
    word_token_t     token;
    remaining = 64'(number);
    // anything above the named groups simply falls off here
    for (int g = 0; g < GROUP_COUNT; g++) begin
      groups[g] = int'(remaining % 1000);
      remaining = remaining / 1000;
    end
    for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
      hundreds    = groups[g] / 100;
      rest        = groups[g] % 100;
      group_start = codes.size();
      if (hundreds != 0) begin
        codes.push_back(word_code_t'(hundreds));
        codes.push_back(CODE_HUNDRED);
      end
      if (rest >= 10 && rest < 20) begin
        // teens are one word
        codes.push_back(CODE_TEN + word_code_t'(rest - 10));
      end else begin
        if (rest >= 20) begin
          codes.push_back(CODE_TENS_BASE + word_code_t'(rest / 10));
        end
        if (rest % 10 != 0) begin
          codes.push_back(word_code_t'(rest % 10));
        end
      end
      // scale words follow hundred: thousand, million, billion
      if (g > 0 && codes.size() > group_start) begin
        codes.push_back(CODE_HUNDRED + word_code_t'(g));
      end
    end
    // nothing to name (zero, or only dropped digits): a single empty token
    if (codes.size() == 0) begin
      codes.push_back(CODE_NONE);
    end
    foreach (codes[i]) begin
      token.word_code = codes[i];
      token.last_word = (i == codes.size() - 1);
      expected_tokens.push_back(token);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // random numbers, shaped so that every group form turns up often
  // ---------------------------------------------------------------------------
  function automatic int unsigned random_group();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(10, 19);
      2:       return 10 * $urandom_range(2, 9);
      3:       return 100 * $urandom_range(1, 9);
      4:       return 100 * $urandom_range(1, 9) + $urandom_range(0, 99);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  function automatic logic [NUM_W-1:0] random_number();
    longint unsigned value;
    int unsigned     level;
    value = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
          value = value * 1000 + random_group();
        end
      end
      6: value = $urandom_range(0, 999);
      // raw bit patterns over the whole field
      7: value = {$urandom, $urandom};
      // one trillion and above: top digits are dropped
      8: value = TRILLION + ({$urandom, $urandom} % ABOVE_SPAN);
      default: begin
        // a single group, possibly empty, at a random scale
        level = $urandom_range(0, GROUP_COUNT - 1);
        value = random_group();
        repeat (level) value = value * 1000;
      end
    endcase
    return value[NUM_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers one number and waits for its transaction; with gaps on it
  // works in bursts of random length separated by random idle stretches
  // ---------------------------------------------------------------------------
  task automatic send_number(input logic [NUM_W-1:0] number);
    if (sender_gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (!in_ready);
    predict_tokens(number);
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // stop offering and wait for every outstanding token
  task automatic drain_tokens();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every word class, teens, empty groups, dropped digits
  task automatic test_directed();
    logic [NUM_W-1:0] directed_numbers[$];
    directed_numbers = '{
      40'd0, 40'd1, 40'd9, 40'd10, 40'd13, 40'd19, 40'd20, 40'd21, 40'd99,
      40'd100, 40'd101, 40'd110, 40'd999, 40'd1000, 40'd1001, 40'd1000000,
      40'd1000000000, 40'd100000000000, 40'd20000020, 40'd17017017017,
      40'd123456789012, 40'd999999999999, 40'd1000000000000,
      40'd1000000000017, 40'hFF_FFFF_FFFF
    };
    foreach (directed_numbers[i]) begin
      send_number(directed_numbers[i]);
    end
  endtask

  // bulk of the run: random numbers with the sender in bursts
  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_number(random_number());
  endtask

  // back to back offers with no sender idling at all
  task automatic test_back_to_back(input int unsigned count);
    sender_gaps_on = 1'b0;
    repeat (count) send_number(random_number());
    sender_gaps_on = 1'b1;
  endtask

  // receiver holds off for a long stretch while numbers keep coming, so the
  // pipeline fills and in_ready drops
  task automatic test_output_backpressure(input int unsigned count);
    sender_gaps_on = 1'b0;
    stall_requests++;
    repeat (count) send_number(random_number());
    sender_gaps_on = 1'b1;
  endtask

  // sender stops until every token has come out, then resumes
  task automatic test_drain_pause(input int unsigned count);
    repeat (count) send_number(random_number());
    drain_tokens();
    repeat (count) send_number(random_number());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(120);
    test_back_to_back(30);
    test_output_backpressure(30);
    test_drain_pause(10);
    test_random_traffic(140);
    drain_tokens();
    // let any stray token show up before deciding
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: ready follows patterns of random length, with a long hold-off
  // whenever one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stalls_served != stall_requests) begin
      stalls_served = stall_requests;
      hold_left     = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        rx_mode      = rx_pattern_t'($urandom_range(0, 3));
        stretch_left = $urandom_range(20, 200);
        rx_period    = $urandom_range(2, 6);
      end
      stretch_left--;
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS:   out_ready <= 1'b1;
        RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
        RX_PERIODIC: out_ready <= (rx_phase % rx_period == 0);
        default:     out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each output transaction against the oldest expected token
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_token_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        error_count++;
        $display("%0t: unexpected token, expected none, actual code %0d last %0b",
                 $time, out_word_code, out_last_word);
      end else begin
        want = expected_tokens.pop_front();
        if (out_word_code !== want.word_code) begin
          error_count++;
          $display("%0t: token %0d word_code expected %0d actual %0d",
                   $time, tokens_checked, want.word_code, out_word_code);
        end
        if (out_last_word !== want.last_word) begin
          error_count++;
          $display("%0t: token %0d last_word expected %0b actual %0b",
                   $time, tokens_checked, want.last_word, out_last_word);
        end
      end
      tokens_checked++;
    end
  end

  // watchdog: a long run of cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d tokens still expected", $time, expected_tokens.size());
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule

### sim.f
hdl/n2w_pkg.sv
hdl/n2w_bcd_stage.sv
hdl/n2w_token_build.sv
hdl/n2w_token_ser.sv
hdl/number_to_word_tokens_top.sv
hdl/n2w_checker.sv
verif/tb_top.sv
